### sv/fp32_reciprocal_sqrt_ftz_top_defines.svh
// Assertion macros shared by the reciprocal square root block.
`ifndef FP32_RECIPROCAL_SQRT_FTZ_TOP_DEFINES_SVH
`define FP32_RECIPROCAL_SQRT_FTZ_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RSQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsq assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RSQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsq assertion failed");

`endif

### sv/rsq_pkg.sv
// Shared types and constants for the reciprocal square root pipeline.
package rsq_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned EXP_W    = 8;
	localparam int unsigned FRAC_W   = 23;
	localparam int unsigned SIG_W    = 24;
	localparam int unsigned RAD_W    = 48;
	localparam int unsigned SREM_W   = 26;
	localparam int unsigned ROOT_W   = 24;

	// Iterations done in each stage of both the root and the divide chains
	localparam int unsigned STEPS_DEFAULT = 4;

	localparam logic [WORD_W-1:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [WORD_W-1:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [WORD_W-1:0] ZERO_BITS = 32'h0000_0000;
	localparam logic [WORD_W-1:0] MIN_NORM  = 32'h0080_0000;
	localparam logic [SIG_W-1:0]  HIDDEN    = 24'h80_0000;

	typedef struct packed {
		logic              spec;      // result is a special value
		logic [WORD_W-1:0] spec_val;
		logic              unit;      // rounded root is a power of two
		logic [EXP_W-1:0]  exp_b;     // result exponent before quotient carry
	} meta_t;

endpackage

### sv/rsq_sqrt_stage.sv
// One registered stage of the digit-by-digit square root.
module rsq_sqrt_stage #(
	parameter int unsigned STEPS = rsq_pkg::STEPS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_i,
	input  rsq_pkg::meta_t              meta_i,
	input  logic [rsq_pkg::RAD_W-1:0]   rad_i,
	input  logic [rsq_pkg::SREM_W-1:0]  rem_i,
	input  logic [rsq_pkg::ROOT_W-1:0]  root_i,
	output logic                        valid_o,
	output rsq_pkg::meta_t              meta_o,
	output logic [rsq_pkg::RAD_W-1:0]   rad_o,
	output logic [rsq_pkg::SREM_W-1:0]  rem_o,
	output logic [rsq_pkg::ROOT_W-1:0]  root_o
);
	import rsq_pkg::*;

	logic [RAD_W-1:0]  rad_n;
	logic [SREM_W-1:0] rem_n;
	logic [ROOT_W-1:0] root_n;

	always_comb begin
		logic [SREM_W+1:0] cur;
		logic [SREM_W+1:0] trial;
		rad_n  = rad_i;
		rem_n  = rem_i;
		root_n = root_i;
		for (int k = 0; k < STEPS; k++) begin
			cur   = {rem_n, rad_n[RAD_W-1 -: 2]};
			trial = {2'b00, root_n, 2'b01};
			if (cur >= trial) begin
				rem_n  = SREM_W'(cur - trial);
				root_n = {root_n[ROOT_W-2:0], 1'b1};
			end else begin
				rem_n  = cur[SREM_W-1:0];
				root_n = {root_n[ROOT_W-2:0], 1'b0};
			end
			rad_n = {rad_n[RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_o <= meta_i;
			rad_o  <= rad_n;
			rem_o  <= rem_n;
			root_o <= root_n;
		end
	end

endmodule

### sv/rsq_div_stage.sv
// One registered stage of the restoring reciprocal divider.
module rsq_div_stage #(
	parameter int unsigned STEPS = rsq_pkg::STEPS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_i,
	input  rsq_pkg::meta_t             meta_i,
	input  logic [rsq_pkg::SIG_W-1:0]  dvs_i,
	input  logic [rsq_pkg::SIG_W-1:0]  rem_i,
	input  logic [rsq_pkg::SIG_W-1:0]  quo_i,
	output logic                       valid_o,
	output rsq_pkg::meta_t             meta_o,
	output logic [rsq_pkg::SIG_W-1:0]  dvs_o,
	output logic [rsq_pkg::SIG_W-1:0]  rem_o,
	output logic [rsq_pkg::SIG_W-1:0]  quo_o
);
	import rsq_pkg::*;

	logic [SIG_W-1:0] rem_n;
	logic [SIG_W-1:0] quo_n;

	always_comb begin
		logic [SIG_W:0] t;
		rem_n = rem_i;
		quo_n = quo_i;
		for (int k = 0; k < STEPS; k++) begin
			t = {rem_n, 1'b0};
			if (t >= {1'b0, dvs_i}) begin
				rem_n = SIG_W'(t - {1'b0, dvs_i});
				quo_n = {quo_n[SIG_W-2:0], 1'b1};
			end else begin
				rem_n = t[SIG_W-1:0];
				quo_n = {quo_n[SIG_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_o <= meta_i;
			dvs_o  <= dvs_i;
			rem_o  <= rem_n;
			quo_o  <= quo_n;
		end
	end

endmodule

### sv/fp32_reciprocal_sqrt_ftz_top.sv
// Top level of the pipelined single-precision reciprocal square root.
//
// Computes 1/sqrt(x) for one binary32 word per cycle as round(1/round(sqrt(x))),
// both roundings to nearest-even. Denormal inputs count as zero and give
// infinity of the input's sign; NaNs and negative values give 0x7FC00000;
// +inf gives +0. Every transfer in is followed by exactly one transfer out,
// in order, after passing through the registers of the pipe in turn:
// a chain of root stages, a rounding stage, a chain of divide stages and an
// output rounding register. The whole pipe advances together whenever the
// output register is empty or its result is taken, so a new operand is taken
// every cycle as long as results drain; operand_stall rises only while a
// finished result sits unclaimed under result_stall. STEPS_PER_STAGE sets the
// iterations per stage and must divide 24.
`include "fp32_reciprocal_sqrt_ftz_top_defines.svh"

module fp32_reciprocal_sqrt_ftz_top #(
	parameter int unsigned STEPS_PER_STAGE = rsq_pkg::STEPS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        operand_valid,
	output logic                        operand_stall,
	input  logic [rsq_pkg::WORD_W-1:0]  operand_bits,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [rsq_pkg::WORD_W-1:0]  result_word
);
	import rsq_pkg::*;

	localparam int unsigned NST = ROOT_W / STEPS_PER_STAGE;

	// Global advance: move everything when the output slot is free or drains
	logic en;
	assign en            = !result_valid || !result_stall;
	assign operand_stall = !en;

	// Front decode: classify the operand and build the radicand
	logic [WORD_W-1:0] mag;
	logic [EXP_W-1:0]  e_in;
	logic [SIG_W:0]    sig25;
	logic signed [8:0] half_exp;
	meta_t             meta_in;

	always_comb begin
		mag      = {1'b0, operand_bits[WORD_W-2:0]};
		e_in     = operand_bits[WORD_W-2 -: EXP_W];
		// Make the exponent even by folding an odd one into the significand
		sig25    = e_in[0] ? {1'b0, 1'b1, operand_bits[FRAC_W-1:0]}
		                   : {1'b1, operand_bits[FRAC_W-1:0], 1'b0};
		half_exp = ($signed({1'b0, e_in}) - 9'sd127) >>> 1;
		meta_in.unit  = 1'b0;
		meta_in.exp_b = EXP_W'(9'sd126 - half_exp);
		meta_in.spec  = 1'b1;
		if (mag > INF_BITS) begin
			meta_in.spec_val = QNAN_BITS;
		end else if (mag < MIN_NORM) begin
			meta_in.spec_val = {operand_bits[WORD_W-1], INF_BITS[WORD_W-2:0]};
		end else if (operand_bits[WORD_W-1]) begin
			meta_in.spec_val = QNAN_BITS;
		end else if (mag == INF_BITS) begin
			meta_in.spec_val = ZERO_BITS;
		end else begin
			meta_in.spec     = 1'b0;
			meta_in.spec_val = ZERO_BITS;
		end
	end

	// Square root chain
	logic              sq_v    [NST+1];
	meta_t             sq_meta [NST+1];
	logic [RAD_W-1:0]  sq_rad  [NST+1];
	logic [SREM_W-1:0] sq_rem  [NST+1];
	logic [ROOT_W-1:0] sq_root [NST+1];

	assign sq_v[0]    = operand_valid;
	assign sq_meta[0] = meta_in;
	assign sq_rad[0]  = {sig25, {(RAD_W-SIG_W-1){1'b0}}};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < NST; i++) begin : g_sqrt
		rsq_sqrt_stage #(.STEPS(STEPS_PER_STAGE)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (sq_v[i]),
			.meta_i  (sq_meta[i]),
			.rad_i   (sq_rad[i]),
			.rem_i   (sq_rem[i]),
			.root_i  (sq_root[i]),
			.valid_o (sq_v[i+1]),
			.meta_o  (sq_meta[i+1]),
			.rad_o   (sq_rad[i+1]),
			.rem_o   (sq_rem[i+1]),
			.root_o  (sq_root[i+1])
		);
	end

	// Round the root: an exact half cannot occur, so round up when rem > root
	logic [ROOT_W:0] r_inc;
	logic            r_ovf;
	meta_t           rnd_meta;
	logic            rnd_valid_q;
	meta_t           rnd_meta_q;
	logic [SIG_W-1:0] rnd_r_q;

	always_comb begin
		r_inc    = {1'b0, sq_root[NST]}
		         + (ROOT_W+1)'(sq_rem[NST] > {2'b00, sq_root[NST]});
		r_ovf    = r_inc[ROOT_W];
		rnd_meta = sq_meta[NST];
		rnd_meta.unit  = r_ovf || (r_inc[ROOT_W-1:0] == HIDDEN);
		rnd_meta.exp_b = sq_meta[NST].exp_b - EXP_W'(r_ovf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_valid_q <= 1'b0;
		end else if (en) begin
			rnd_valid_q <= sq_v[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_meta_q <= rnd_meta;
			rnd_r_q    <= r_ovf ? HIDDEN : r_inc[ROOT_W-1:0];
		end
	end

	// Divide chain: 2^47 / r, starting from the partial remainder 2^23
	logic             dv_v    [NST+1];
	meta_t            dv_meta [NST+1];
	logic [SIG_W-1:0] dv_dvs  [NST+1];
	logic [SIG_W-1:0] dv_rem  [NST+1];
	logic [SIG_W-1:0] dv_quo  [NST+1];

	assign dv_v[0]    = rnd_valid_q;
	assign dv_meta[0] = rnd_meta_q;
	assign dv_dvs[0]  = rnd_r_q;
	assign dv_rem[0]  = HIDDEN;
	assign dv_quo[0]  = '0;

	for (genvar i = 0; i < NST; i++) begin : g_div
		rsq_div_stage #(.STEPS(STEPS_PER_STAGE)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (dv_v[i]),
			.meta_i  (dv_meta[i]),
			.dvs_i   (dv_dvs[i]),
			.rem_i   (dv_rem[i]),
			.quo_i   (dv_quo[i]),
			.valid_o (dv_v[i+1]),
			.meta_o  (dv_meta[i+1]),
			.dvs_o   (dv_dvs[i+1]),
			.rem_o   (dv_rem[i+1]),
			.quo_o   (dv_quo[i+1])
		);
	end

	// Round the quotient to nearest-even and pack
	logic [SIG_W:0]    rem2;
	logic              q_up;
	logic [SIG_W:0]    q_inc;
	logic              bump;
	logic [WORD_W-1:0] packed_res;
	logic              res_spec_q;

	always_comb begin
		rem2  = {dv_rem[NST], 1'b0};
		q_up  = (rem2 > {1'b0, dv_dvs[NST]})
		     || ((rem2 == {1'b0, dv_dvs[NST]}) && dv_quo[NST][0]);
		q_inc = {1'b0, dv_quo[NST]} + (SIG_W+1)'(q_up);
		// A power-of-two root or a quotient carry both land on a bare exponent
		bump  = dv_meta[NST].unit || q_inc[SIG_W];
		if (dv_meta[NST].spec) begin
			packed_res = dv_meta[NST].spec_val;
		end else begin
			packed_res = {1'b0, dv_meta[NST].exp_b + EXP_W'(bump),
			              bump ? {FRAC_W{1'b0}} : q_inc[FRAC_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= dv_v[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_word <= packed_res;
			res_spec_q  <= dv_meta[NST].spec;
		end
	end

	// Positive, with an exponent that is neither zero nor all ones
	logic res_normal;
	assign res_normal = !result_word[WORD_W-1]
	                 && (result_word[WORD_W-2 -: EXP_W] != {EXP_W{1'b0}})
	                 && (result_word[WORD_W-2 -: EXP_W] != {EXP_W{1'b1}});

	// Stall back to the source only while a result waits at the output
	`RSQ_ASSERT_NOW(a_stall_only_when_full, operand_stall, result_valid)
	// A computed (non-special) result is always a positive normal number
	`RSQ_ASSERT_NOW(a_normal_result, result_valid && !res_spec_q, res_normal)
	// An item that leaves the last divide stage lands in the output register
	`RSQ_ASSERT_NEXT(a_out_follows, dv_v[NST] && en, result_valid)

endmodule
